@@ sv/ptw_pkg.sv @@
// Shared types, constants and helper functions for the page table walker.
`default_nettype none

package ptw_pkg;

  localparam int unsigned STORE_WORDS_DEFAULT = 4096;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW = 1;
  localparam int unsigned SLOT_W = 45;
  localparam logic [63:0] ALL_ONES = '1;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_WALK  = 1'b1
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef struct packed {
    cmd_kind_t    kind;
    logic [11:0]  widx;
    logic [63:0]  wdata;
    logic [35:0]  root;
    logic [47:0]  va;
  } cmd_t;

  function automatic logic [8:0] va_index(input logic [47:0] va, input logic [1:0] level);
    logic [8:0] idx;
    case (level)
      2'd0: idx = va[47:39];
      2'd1: idx = va[38:30];
      2'd2: idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  function automatic logic [63:0] offset_mask(input logic [1:0] level);
    logic [63:0] mask;
    case (level)
      2'd0: mask = {25'd0, {39{1'b1}}};
      2'd1: mask = {34'd0, {30{1'b1}}};
      2'd2: mask = {43'd0, {21{1'b1}}};
      default: mask = {52'd0, {12{1'b1}}};
    endcase
    return mask;
  endfunction

endpackage

`default_nettype wire

@@ sv/ptw_front.sv @@
// Front end: accepts words, drops writes outside the store and queues commands.
`default_nettype none

module ptw_front
  import ptw_pkg::*;
#(
  parameter int unsigned STORE_WORDS = STORE_WORDS_DEFAULT
) (
  input  wire logic        start,
  output logic             busy,
  input  wire logic        op,
  input  wire logic [11:0] word_index,
  input  wire logic [63:0] word_data,
  input  wire logic [47:0] root_table,
  input  wire logic [47:0] virt_addr,
  input  wire logic        q_full,
  input  wire logic        clearing,
  output logic             q_push,
  output cmd_t             q_item
);

  logic accept;
  logic write_ok;

  assign busy     = q_full | clearing;
  assign accept   = start & ~busy;
  assign write_ok = (32'(word_index) < 32'(STORE_WORDS));

  always_comb begin
    q_item.kind  = op ? CMD_WALK : CMD_WRITE;
    q_item.widx  = word_index;
    q_item.wdata = word_data;
    q_item.root  = root_table[47:12];
    q_item.va    = virt_addr;
    q_push       = accept & (op | write_ok);
  end

endmodule

`default_nettype wire

@@ sv/ptw_fifo.sv @@
// Two-entry command queue between the front end and the walk engine.
`default_nettype none

module ptw_fifo
  import ptw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_item,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty,
  output logic      full
);

  cmd_t             slots [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr;
  logic [Q_AW-1:0]  rd_ptr;
  logic [Q_AW:0]    count;

  assign empty = (count == '0);
  assign full  = (count == (Q_AW+1)'(Q_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/ptw_back.sv @@
// Walk engine: owns the descriptor store, clears it after reset, applies writes and runs walks.
`default_nettype none

module ptw_back
  import ptw_pkg::*;
#(
  parameter int unsigned STORE_WORDS = STORE_WORDS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        head,
  input  wire logic        empty,
  output logic             pop,
  output logic             clearing,
  output logic             done,
  output logic [63:0]      phys_addr,
  output status_t          status,
  output logic [1:0]       leaf_level
);

  localparam int unsigned AW = $clog2(STORE_WORDS);
  localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(STORE_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_WORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_WALK  = 3'b100
  } state_t;

  logic [63:0]        store [STORE_WORDS];
  logic [63:0]        rd_data;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [63:0]        mem_wdata;
  logic [AW-1:0]      mem_raddr;

  state_t             state, state_next;
  logic [AW-1:0]      clr_addr;
  logic [1:0]         level, level_next;
  logic [47:0]        va, va_next;
  logic               done_next;
  logic [63:0]        phys_next;
  status_t            status_next;
  logic [1:0]         leaf_next;

  logic [1:0]         next_level;
  logic [SLOT_W-1:0]  slot;
  logic               slot_ok;

  assign clearing   = (state == S_CLEAR);
  assign next_level = level + 2'd1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    rd_data <= store[mem_raddr];
  end

  always_comb begin
    if (state == S_IDLE) begin
      slot = {head.root, va_index(head.va, 2'd0)};
    end else begin
      slot = {rd_data[47:12], va_index(va, next_level)};
    end
    slot_ok = (slot < SLOT_LIMIT);
  end

  always_comb begin
    state_next  = state;
    level_next  = level;
    va_next     = va;
    done_next   = 1'b0;
    phys_next   = phys_addr;
    status_next = status;
    leaf_next   = leaf_level;
    pop         = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = clr_addr;
    mem_wdata   = '0;
    mem_raddr   = slot[AW-1:0];
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (head.kind == CMD_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(head.widx);
            mem_wdata = head.wdata;
          end else begin
            va_next    = head.va;
            level_next = 2'd0;
            if (slot_ok) begin
              state_next = S_WALK;
            end else begin
              done_next   = 1'b1;
              phys_next   = ALL_ONES;
              status_next = ST_RANGE;
              leaf_next   = 2'd0;
            end
          end
        end
      end
      S_WALK: begin
        if (!rd_data[0]) begin
          state_next  = S_IDLE;
          done_next   = 1'b1;
          phys_next   = ALL_ONES;
          status_next = ST_INVALID;
          leaf_next   = level;
        end else if (rd_data[1] && level != 2'd3) begin
          level_next = next_level;
          if (!slot_ok) begin
            state_next  = S_IDLE;
            done_next   = 1'b1;
            phys_next   = ALL_ONES;
            status_next = ST_RANGE;
            leaf_next   = next_level;
          end
        end else begin
          state_next  = S_IDLE;
          done_next   = 1'b1;
          phys_next   = {16'd0, rd_data[47:12], 12'd0} | ({16'd0, va} & offset_mask(level));
          status_next = ST_OK;
          leaf_next   = level;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    level      <= level_next;
    va         <= va_next;
    phys_addr  <= phys_next;
    status     <= status_next;
    leaf_level <= leaf_next;
  end

endmodule

`default_nettype wire

@@ sv/page_table_walker.sv @@
// Top level of the four-level page table walker.
//
//   Channel   Handshake              Payload
//   command   start in, busy out     op, word_index, word_data, root_table, virt_addr
//   result    done out (one cycle)   phys_addr, status, leaf_level
//
// After reset the descriptor store is cleared one word per cycle, with busy
// held high.
// A write word is written into the store by the walk engine and gives no result.
// A translate takes a dispatch step in the walk engine, then one descriptor read per
// level walked; each read depends on the one before, so the reads run in sequence.
// An accepted command passes through the command queue before the walk engine takes it; the result is registered.
// After the clear, busy rises only while the two-entry command queue is full;
// results cannot stall.
`default_nettype none

module page_table_walker
  import ptw_pkg::*;
#(
  parameter int unsigned STORE_WORDS = STORE_WORDS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        op,
  input  wire logic [11:0] word_index,
  input  wire logic [63:0] word_data,
  input  wire logic [47:0] root_table,
  input  wire logic [47:0] virt_addr,
  output logic             done,
  output logic [63:0]      phys_addr,
  output logic [1:0]       status,
  output logic [1:0]       leaf_level
);

  logic    q_push;
  cmd_t    q_item;
  cmd_t    q_head;
  logic    q_empty;
  logic    q_full;
  logic    q_pop;
  logic    clearing;
  status_t status_code;

  assign status = status_code;

  ptw_front #(
    .STORE_WORDS(STORE_WORDS)
  ) u_front (
    .start      (start),
    .busy       (busy),
    .op         (op),
    .word_index (word_index),
    .word_data  (word_data),
    .root_table (root_table),
    .virt_addr  (virt_addr),
    .q_full     (q_full),
    .clearing   (clearing),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  ptw_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  ptw_back #(
    .STORE_WORDS(STORE_WORDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .clearing   (clearing),
    .done       (done),
    .phys_addr  (phys_addr),
    .status     (status_code),
    .leaf_level (leaf_level)
  );

endmodule

`default_nettype wire
